// ===== rtl/core/tilt_pkg.sv =====
package tilt_pkg;

   localparam int ATAN_LEN = 24;
   localparam int ATAN_IW  = 5;
   localparam int Z_FRAC   = 24;
   localparam int ZW       = 33;
   localparam int XW       = 36;
   localparam int SUM_W    = 32;
   localparam int ROOT_W   = 32;
   localparam int NUM_W    = 17;
   localparam int Y0_W     = NUM_W + 16;

   // atan(2^-i) in degrees, 24 fraction bits
   localparam logic [29:0] ATAN_DEG_Q24 [ATAN_LEN] = '{
      30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
      30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
      30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
      30'd234684,    30'd117342,    30'd58671,     30'd29335,
      30'd14668,     30'd7334,      30'd3667,      30'd1833,
      30'd917,       30'd458,       30'd229,       30'd115
   };

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ1,
      ST_SQ2,
      ST_CHECK,
      ST_SQRT,
      ST_CORDIC,
      ST_FINISH
   } tilt_state_type;

endpackage

// ===== rtl/core/tilt_if.sv =====
interface tilt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [15:0] reading;

   modport source (output valid, output func, output reading, input ready);
   modport sink   (input valid, input func, input reading, output ready);
endinterface

interface tilt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pitch_deg;
   logic signed [15:0] roll_deg;

   modport source (output valid, output pitch_deg, output roll_deg, input ready);
   modport sink   (input valid, input pitch_deg, input roll_deg, output ready);
endinterface

// ===== rtl/core/accel_tilt_angle_engine_core.sv =====
// Tilt angle engine: each request carries one accelerometer reading and its axis
// (0 = X, 1 = Y, 2 = Z); a nonzero reading replaces the held value of that axis,
// a zero reading or axis code 3 leaves the held values as they are. Every request
// gives one response with pitch = atan(-ax/sqrt(ay^2+az^2)) and
// roll = atan(ay/sqrt(ax^2+az^2)) in signed degrees with ANGLE_FRAC_BITS fraction
// bits, clamped to +-90 degrees and to the 16-bit range; a zero numerator gives 0
// and a zero denominator gives +-90. One request is processed at a time: both
// angles go in turn through a shared 16x16 squarer, a bit-per-cycle square root
// and a CORDIC unit that runs one rotation per cycle; an angle that hits a zero
// case skips the square root and the CORDIC unit. A new request is accepted only
// after the response of the last one is loaded. The response sits in an output
// register, so the next request is accepted while it waits.
module accel_tilt_angle_engine_core
   import tilt_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int CORDIC_STEPS    = 16
) (
   input  logic              clock,
   input  logic              reset,
   tilt_req_if.sink          req_ch,
   tilt_rsp_if.source        rsp_ch
);

   localparam int     SHIFT    = Z_FRAC - ANGLE_FRAC_BITS;
   localparam int     RW       = ZW + 1;
   localparam longint LIMIT    = longint'(90) << ANGLE_FRAC_BITS;
   localparam longint SAT_HI_L = (LIMIT > 32767) ? 32767 : LIMIT;
   localparam longint SAT_LO_L = (-LIMIT < -32768) ? -32768 : -LIMIT;
   localparam logic signed [15:0]   SAT_HI = 16'(SAT_HI_L);
   localparam logic signed [15:0]   SAT_LO = 16'(SAT_LO_L);
   localparam logic signed [RW-1:0] HI_R   = RW'(SAT_HI_L);
   localparam logic signed [RW-1:0] LO_R   = RW'(SAT_LO_L);
   localparam logic signed [RW-1:0] RND    = RW'(64'd1 << (SHIFT - 1));

   function automatic logic signed [15:0] round_angle(input logic signed [ZW-1:0] zv);
      logic signed [RW-1:0] t;
      t = (RW'(zv) + RND) >>> SHIFT;
      if (t > HI_R) begin
         return SAT_HI;
      end else if (t < LO_R) begin
         return SAT_LO;
      end
      return 16'(t);
   endfunction

   tilt_state_type        state_ff, state_in;
   logic signed [15:0]    held_ax_ff, held_ax_in;
   logic signed [15:0]    held_ay_ff, held_ay_in;
   logic signed [15:0]    held_az_ff, held_az_in;
   logic                  sel_ff, sel_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [15:0]    res_p_ff, res_p_in;
   logic signed [15:0]    res_r_ff, res_r_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]    rsp_pitch_ff, rsp_pitch_in;
   logic signed [15:0]    rsp_roll_ff, rsp_roll_in;

   logic signed [NUM_W-1:0] num;
   logic signed [15:0]      d1;
   logic signed [15:0]      m_op;
   logic signed [31:0]      sq;
   logic signed [Y0_W-1:0]  y0;
   logic                    sqrt_start;
   logic                    sqrt_done;
   logic [ROOT_W-1:0]       root;
   logic                    cordic_start;
   logic                    cordic_done;
   logic signed [ZW-1:0]    z;
   logic                    res_wr;
   logic signed [15:0]      res_val;

   // operand select: pitch first, then roll
   always_comb begin
      num  = sel_ff ? NUM_W'(held_ay_ff) : -NUM_W'(held_ax_ff);
      d1   = sel_ff ? held_ax_ff : held_ay_ff;
      m_op = (state_ff == ST_SQ1) ? d1 : held_az_ff;
      sq   = m_op * m_op;
      y0   = $signed({num, 16'h0000});
   end

   tilt_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   tilt_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x0    (root),
      .y0    (y0),
      .done  (cordic_done),
      .z     (z)
   );

   always_comb begin
      state_in     = state_ff;
      held_ax_in   = held_ax_ff;
      held_ay_in   = held_ay_ff;
      held_az_in   = held_az_ff;
      sel_in       = sel_ff;
      sum_in       = sum_ff;
      res_p_in     = res_p_ff;
      res_r_in     = res_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_roll_in  = rsp_roll_ff;
      sqrt_start   = 1'b0;
      cordic_start = 1'b0;
      res_wr       = 1'b0;
      res_val      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.reading != 16'sd0) begin
                  unique case (axis_type'(req_ch.func))
                     AXIS_X:  held_ax_in = req_ch.reading;
                     AXIS_Y:  held_ay_in = req_ch.reading;
                     AXIS_Z:  held_az_in = req_ch.reading;
                     default: ;
                  endcase
               end
               sel_in   = 1'b0;
               state_in = ST_SQ1;
            end
         end
         ST_SQ1: begin
            sum_in   = $unsigned(sq);
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            sum_in   = sum_ff + $unsigned(sq);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (num == '0) begin
               res_wr = 1'b1;
            end else if (sum_ff == '0) begin
               res_wr  = 1'b1;
               res_val = num[NUM_W-1] ? SAT_LO : SAT_HI;
            end else begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               cordic_start = 1'b1;
               state_in     = ST_CORDIC;
            end
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               res_wr  = 1'b1;
               res_val = round_angle(z);
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pitch_in = res_p_ff;
               rsp_roll_in  = res_r_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (res_wr) begin
         if (!sel_ff) begin
            res_p_in = res_val;
            sel_in   = 1'b1;
            state_in = ST_SQ1;
         end else begin
            res_r_in = res_val;
            state_in = ST_FINISH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_ax_ff   <= '0;
         held_ay_ff   <= '0;
         held_az_ff   <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ax_ff   <= held_ax_in;
         held_ay_ff   <= held_ay_in;
         held_az_ff   <= held_az_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff      <= sum_in;
      res_p_ff    <= res_p_in;
      res_r_ff    <= res_r_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_roll_ff  <= rsp_roll_in;
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.pitch_deg = rsp_pitch_ff;
   assign rsp_ch.roll_deg  = rsp_roll_ff;

endmodule

// ===== rtl/core/tilt_isqrt.sv =====
module tilt_isqrt
   import tilt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   localparam int ITERS = ROOT_W;
   localparam int CW    = $clog2(ITERS);
   localparam int RW    = ROOT_W + 2;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]  src_ff, src_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [RW+1:0]     rem_sh;
   logic [RW+1:0]     trial;
   logic [RW+1:0]     diff;

   // radicand is taken as radicand * 2^32, the low half shifts in as zeros
   always_comb begin
      rem_sh  = {rem_ff, src_ff[SUM_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = rem_sh - trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      src_in  = src_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         src_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         if (rem_sh >= trial) begin
            rem_in  = RW'(diff);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = RW'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         src_in = {src_ff[SUM_W-3:0], 2'b00};
         cnt_in = CW'(cnt_ff + 1'b1);
         if (cnt_ff == CW'(ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/core/tilt_cordic.sv =====
module tilt_cordic
   import tilt_pkg::*;
#(
   parameter int STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ROOT_W-1:0]     x0,
   input  logic signed [Y0_W-1:0] y0,
   output logic                  done,
   output logic signed [ZW-1:0]  z
);

   localparam int CW = $clog2(STEPS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        step_ff, step_in;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic signed [ZW-1:0] av;

   // vectoring mode, one micro-rotation per cycle
   always_comb begin
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      av      = $signed({{(ZW-30){1'b0}}, ATAN_DEG_Q24[ATAN_IW'(step_ff)]});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = $signed(XW'(x0));
         y_in    = XW'(y0);
         z_in    = '0;
      end else if (busy_ff) begin
         if (!y_ff[XW-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + av;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - av;
         end
         step_in = CW'(step_ff + 1'b1);
         if (step_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done = done_ff;
   assign z    = z_ff;

endmodule
